// ===== rtl/itaf_pkg.sv =====
// Package for the integer to ASCII formatter: widths, command codes and character constants.
`timescale 1ns / 1ps
package itaf_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int COMMAND_W       = 3;
  localparam int VALUE_W         = 32;
  localparam int CHAR_W          = 7;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_SDEC  = 3'd0,
    CMD_UDEC  = 3'd1,
    CMD_HEXL  = 3'd2,
    CMD_HEXU  = 3'd3,
    CMD_PTR   = 3'd4
  } command_t;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
  localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;
  localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [3:0]        RADIX_DEC = 4'd10;

  // Number of decimal digits needed for a w-bit unsigned value.
  // 1233 / 4096 is a close lower bound of log10(2) over the supported widths.
  function automatic int dec_digits(input int w);
    return ((w * 1233) >> 12) + 1;
  endfunction

endpackage

// ===== rtl/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter: one value in, its characters out most significant first.
//
// A command is transferred at a rising edge where start is high and busy is low.
// The block then raises busy until the final character of that value has gone out.
// Each character appears on char_code for exactly one cycle with strobe high;
// last marks the final character. The receiver cannot stall the output.
// Decimal commands first run a shift-and-add-3 binary to BCD converter, one bit a
// cycle, then skip leading zero digits one a cycle and leave the skip phase once
// the top digit is nonzero or one digit is left, then emit one character a cycle.
// Hex commands go straight to the skip phase; the pointer command emits "0x" and
// all digits with no skip. Busy time on a decimal value does not depend on how many
// digits it has, but a minus sign lengthens it. The next transfer can take place at
// the edge that ends the first cycle with busy low; no new value is taken while busy.
// Commands 5 to 7 are accepted and give no characters.
// A synchronous reset returns the sequencer to idle and drops any value in progress.
`timescale 1ns / 1ps
module integer_to_ascii_formatter
  import itaf_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [COMMAND_W-1:0] command,
  input  logic [VALUE_W-1:0]   value,
  output logic                 strobe,
  output logic [CHAR_W-1:0]    char_code,
  output logic                 last
);

  localparam int NDIG   = dec_digits(VALUE_WIDTH);
  localparam int HEXDIG = (VALUE_WIDTH + 3) / 4;
  localparam int DIG_W  = NDIG * 4;
  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CONV  = 7'b0000010,
    S_SKIP  = 7'b0000100,
    S_SIGN  = 7'b0001000,
    S_PRE0  = 7'b0010000,
    S_PREX  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t                 state, state_next;
  logic [VALUE_WIDTH-1:0] mag, mag_next;
  logic [DIG_W-1:0]       dig, dig_next;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic                   neg, neg_next;
  logic                   upper, upper_next;

  logic [VALUE_WIDTH-1:0] v_in;
  logic [HEXDIG*4-1:0]    hex_in;
  logic [DIG_W-1:0]       dig_adj;
  logic [3:0]             top_digit;
  logic                   accept;

  assign accept    = start && (state == S_IDLE);
  assign v_in      = VALUE_WIDTH'(value);
  assign hex_in    = (HEXDIG * 4)'(v_in);
  assign top_digit = dig[DIG_W-1 -: 4];

  // Add 3 to every BCD digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (dig[i*4 +: 4] >= 4'd5) begin
        dig_adj[i*4 +: 4] = dig[i*4 +: 4] + 4'd3;
      end else begin
        dig_adj[i*4 +: 4] = dig[i*4 +: 4];
      end
    end
  end

  always_comb begin
    state_next = state;
    mag_next   = mag;
    dig_next   = dig;
    cnt_next   = cnt;
    neg_next   = neg;
    upper_next = upper;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          neg_next   = 1'b0;
          upper_next = (command == CMD_HEXU);
          unique case (command) inside
            CMD_SDEC, CMD_UDEC: begin
              neg_next   = (command == CMD_SDEC) && v_in[VALUE_WIDTH-1];
              mag_next   = ((command == CMD_SDEC) && v_in[VALUE_WIDTH-1]) ? (~v_in + 1'b1)
                                                                         : v_in;
              dig_next   = '0;
              cnt_next   = CNT_W'(VALUE_WIDTH);
              state_next = S_CONV;
            end
            CMD_HEXL, CMD_HEXU: begin
              dig_next   = DIG_W'(hex_in) << ((NDIG - HEXDIG) * 4);
              cnt_next   = CNT_W'(HEXDIG);
              state_next = S_SKIP;
            end
            CMD_PTR: begin
              dig_next   = DIG_W'(hex_in) << ((NDIG - HEXDIG) * 4);
              cnt_next   = CNT_W'(HEXDIG);
              state_next = S_PRE0;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CONV: begin
        dig_next = {dig_adj[DIG_W-2:0], mag[VALUE_WIDTH-1]};
        mag_next = mag << 1;
        if (cnt == CNT_W'(1)) begin
          cnt_next   = CNT_W'(NDIG);
          state_next = S_SKIP;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_SKIP: begin
        if ((top_digit == 4'd0) && (cnt != CNT_W'(1))) begin
          dig_next = dig << 4;
          cnt_next = cnt - 1'b1;
        end else begin
          state_next = neg ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: state_next = S_EMIT;
      S_PRE0: state_next = S_PREX;
      S_PREX: state_next = S_EMIT;
      S_EMIT: begin
        dig_next = dig << 4;
        cnt_next = cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    mag   <= mag_next;
    dig   <= dig_next;
    cnt   <= cnt_next;
    neg   <= neg_next;
    upper <= upper_next;
  end

  always_comb begin
    case (state)
      S_SIGN:  char_code = CH_MINUS;
      S_PRE0:  char_code = CH_ZERO;
      S_PREX:  char_code = CH_X;
      default: begin
        if (top_digit < RADIX_DEC) begin
          char_code = CH_ZERO + CHAR_W'(top_digit);
        end else if (upper) begin
          char_code = CH_UA + CHAR_W'(top_digit - RADIX_DEC);
        end else begin
          char_code = CH_LA + CHAR_W'(top_digit - RADIX_DEC);
        end
      end
    endcase
  end

  assign busy   = (state != S_IDLE);
  assign strobe = (state == S_SIGN) || (state == S_PRE0) || (state == S_PREX) ||
                  (state == S_EMIT);
  assign last   = (state == S_EMIT) && (cnt == CNT_W'(1));

endmodule

// ===== rtl/itaf_checker.sv =====
// Port-level checker for the integer to ASCII formatter, bound to the top level.
`timescale 1ns / 1ps
module itaf_checker
  import itaf_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic [COMMAND_W-1:0] command,
  input logic                 strobe,
  input logic [CHAR_W-1:0]    char_code,
  input logic                 last
);

  // Characters only go out while a value is in progress.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("strobe without busy");

  a_last_strobe: assert property (@(posedge clk) disable iff (rst) last |-> strobe)
    else $error("last without strobe");

  // The final character ends the transfer of that value.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !busy)
    else $error("busy after the final character");

  // An unused command is dropped without any output.
  a_unused_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command != CMD_SDEC) && (command != CMD_UDEC) &&
     (command != CMD_HEXL) && (command != CMD_HEXU) && (command != CMD_PTR)) |=> !busy)
    else $error("unused command started work");

  // The pointer form opens with the character zero in the next cycle.
  a_ptr_prefix: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == CMD_PTR)) |=> (strobe && !last && (char_code == CH_ZERO)))
    else $error("pointer prefix missing");

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (.*);
